/* rtl/core/tempo_map_beat_time_converter_assert.svh */
// Assertion macros for the tempo map converter.
// Needs clk and rst_n in the scope of each use.
`ifndef TEMPO_MAP_BEAT_TIME_CONVERTER_ASSERT_SVH
`define TEMPO_MAP_BEAT_TIME_CONVERTER_ASSERT_SVH

// condition holds at every edge out of reset
`define TMBTC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TMBTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TMBTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tmbtc_pkg.sv */
// Shared types, codes and helpers for the tempo map converter.
// No dependencies.
package tmbtc_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam logic [16:0] MIN_TEMPO         = 17'd10;
  localparam logic [16:0] DEFAULT_TEMPO     = 17'd12000;
  localparam logic [18:0] CENTI_SEC_PER_MIN = 19'd6000;
  localparam logic [18:0] RATE_RESET        = 19'd48000;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_ORDER     = 2'd2;
  localparam logic [1:0] STATUS_ZERO_RATE = 2'd3;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_B2S    = 3'd2,
    MODE_S2B    = 3'd3,
    MODE_TEMPO  = 3'd4,
    MODE_B2SMP  = 3'd5,
    MODE_SMP2B  = 3'd6
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APP_RD,
    ST_SCAN,
    ST_PICK,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_SMUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] beat;
    logic        [16:0] tempo;
    logic signed [31:0] start;
  } point_t;

  function automatic logic [16:0] clamp_tempo(input logic [16:0] t);
    return (t < MIN_TEMPO) ? MIN_TEMPO : t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage

/* rtl/core/tempo_map_beat_time_converter.sv */
// Top level of the tempo map converter: point table, scan sequencer and shared
// multiply / restoring divide unit. Depends on tmbtc_pkg and the assert header.
//
// One item at a time. Clear and table-full or zero-rate items go straight to ST_DONE.
// Conversions scan the point table one entry per cycle from its single registered read
// port. Tempo queries then finish; beats/seconds queries, and appends, which read only
// the last entry, then use the shared multiplier and bit-serial divider. Beats->samples
// adds a second multiply, and samples->beats runs the divider twice. The table needs no
// clearing pass.
`include "tempo_map_beat_time_converter_assert.svh"

module tempo_map_beat_time_converter #(
  parameter int MAX_POINTS = tmbtc_pkg::MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, low bit up: beat_position[32], tempo_centi_bpm[17], time_seconds[32],
  // sample_index[48], zero fill[7]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,
  // in_tuser: mode[3]
  input  logic [2:0]   in_tuser,
  // out_tdata, low bit up: seconds_result[32], beats_result[32], tempo_result[17],
  // samples_result[48], zero fill[7]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,
  // out_tuser: status[2]
  output logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam tmbtc_pkg::point_t DEFAULT_POINT = '{
    beat: 32'sd0, tempo: tmbtc_pkg::DEFAULT_TEMPO, start: 32'sd0};

  tmbtc_pkg::state_t state_r, state_nxt;
  tmbtc_pkg::mode_t  mode_r, mode_nxt, in_mode;

  tmbtc_pkg::point_t mem [MAX_POINTS];
  tmbtc_pkg::point_t rd_data_r;
  tmbtc_pkg::point_t pt_r, pt_nxt;
  tmbtc_pkg::point_t mem_wdata;
  logic [IW-1:0]     rd_addr, mem_waddr;
  logic              mem_we;

  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      chk_idx_r, chk_idx_nxt;
  logic signed [31:0] q_r, q_nxt;
  logic [16:0]        tempo_in_r, tempo_in_nxt;
  logic               phase2_r, phase2_nxt;
  logic [32:0]        mul_a_r, mul_a_nxt;
  logic [18:0]        mul_b_r, mul_b_nxt;
  logic               neg_r, neg_nxt;
  logic [63:0]        dvd_r, dvd_nxt;
  logic [18:0]        rem_r, rem_nxt;
  logic [18:0]        dvs_r, dvs_nxt;
  logic [5:0]         iter_r, iter_nxt;
  logic signed [31:0] base_r, base_nxt;
  logic [18:0]        rate_r;

  logic signed [31:0] res_sec_r, res_sec_nxt, res_beat_r, res_beat_nxt;
  logic [16:0]        res_tempo_r, res_tempo_nxt;
  logic signed [47:0] res_smp_r, res_smp_nxt;
  logic [1:0]         res_status_r, res_status_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_sec_r, out_sec_nxt, out_beat_r, out_beat_nxt;
  logic [16:0]        out_tempo_r, out_tempo_nxt;
  logic signed [47:0] out_smp_r, out_smp_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic signed [31:0] in_beat, in_secs;
  logic [16:0]        in_tempo;
  logic signed [47:0] in_smp;
  logic [47:0]        smp_mag;
  logic               in_acc, full, rate_zero, out_free, by_sec, last, hit;
  logic signed [31:0] scan_key;
  logic [51:0]        prod;
  logic [19:0]        div_sh;
  logic               div_ge;
  logic signed [64:0] quo_s;
  logic signed [65:0] sum_s;
  logic signed [31:0] add_val;
  logic signed [32:0] delta;
  logic [16:0]        pt_tempo_c;

  assign in_beat   = in_tdata[31:0];
  assign in_tempo  = in_tdata[48:32];
  assign in_secs   = in_tdata[80:49];
  assign in_smp    = in_tdata[128:81];
  assign in_mode   = tmbtc_pkg::mode_t'(in_tuser);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (count_r >= CW'(MAX_POINTS));
  assign rate_zero = (rate_r == '0);
  assign out_free  = !out_valid_r || out_tready;
  assign by_sec    = (mode_r == tmbtc_pkg::MODE_S2B) || (mode_r == tmbtc_pkg::MODE_SMP2B);
  assign last      = ((CW'(chk_idx_r) + 1'b1) == count_r);
  assign scan_key  = by_sec ? rd_data_r.start : rd_data_r.beat;
  assign hit       = (scan_key <= q_r);
  assign smp_mag   = in_smp[47] ? 48'(-in_smp) : 48'(in_smp);

  // shared multiplier and divider step
  assign prod    = mul_a_r * mul_b_r;
  assign div_sh  = {rem_r, dvd_r[63]};
  assign div_ge  = (div_sh >= {1'b0, dvs_r});
  assign quo_s   = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
  assign sum_s   = {quo_s[64], quo_s} + {{34{base_r[31]}}, base_r};
  assign add_val = tmbtc_pkg::sat32(sum_s);

  assign pt_tempo_c = tmbtc_pkg::clamp_tempo(pt_r.tempo);
  assign delta = by_sec ? ({q_r[31], q_r} - {pt_r.start[31], pt_r.start})
                        : ({q_r[31], q_r} - {pt_r.beat[31], pt_r.beat});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmbtc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            tmbtc_pkg::MODE_APPEND: begin
              state_nxt = (full || count_r == '0) ? tmbtc_pkg::ST_DONE : tmbtc_pkg::ST_APP_RD;
            end
            tmbtc_pkg::MODE_B2S, tmbtc_pkg::MODE_S2B, tmbtc_pkg::MODE_TEMPO: begin
              state_nxt = (count_r == '0) ? tmbtc_pkg::ST_PICK : tmbtc_pkg::ST_SCAN;
            end
            tmbtc_pkg::MODE_B2SMP: begin
              if (rate_zero) begin
                state_nxt = tmbtc_pkg::ST_DONE;
              end else begin
                state_nxt = (count_r == '0) ? tmbtc_pkg::ST_PICK : tmbtc_pkg::ST_SCAN;
              end
            end
            tmbtc_pkg::MODE_SMP2B: begin
              state_nxt = rate_zero ? tmbtc_pkg::ST_DONE : tmbtc_pkg::ST_DIV;
            end
            default: state_nxt = tmbtc_pkg::ST_DONE;
          endcase
        end
      end
      tmbtc_pkg::ST_APP_RD: begin
        state_nxt = (q_r < rd_data_r.beat) ? tmbtc_pkg::ST_DONE : tmbtc_pkg::ST_PICK;
      end
      tmbtc_pkg::ST_SCAN: begin
        if (!(hit && !last)) begin
          state_nxt = tmbtc_pkg::ST_PICK;
        end
      end
      tmbtc_pkg::ST_PICK: begin
        state_nxt = (mode_r == tmbtc_pkg::MODE_TEMPO) ? tmbtc_pkg::ST_DONE : tmbtc_pkg::ST_MUL;
      end
      tmbtc_pkg::ST_MUL: state_nxt = tmbtc_pkg::ST_DIV;
      tmbtc_pkg::ST_DIV: begin
        if (&iter_r) begin
          state_nxt = tmbtc_pkg::ST_ADD;
        end
      end
      tmbtc_pkg::ST_ADD: begin
        if (mode_r == tmbtc_pkg::MODE_SMP2B && !phase2_r) begin
          state_nxt = (count_r == '0) ? tmbtc_pkg::ST_PICK : tmbtc_pkg::ST_SCAN;
        end else if (mode_r == tmbtc_pkg::MODE_B2SMP) begin
          state_nxt = tmbtc_pkg::ST_SMUL;
        end else begin
          state_nxt = tmbtc_pkg::ST_DONE;
        end
      end
      tmbtc_pkg::ST_SMUL: state_nxt = tmbtc_pkg::ST_DONE;
      tmbtc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = tmbtc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tmbtc_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake, table port, register read
  always_comb begin
    in_tready = (state_r == tmbtc_pkg::ST_IDLE);
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_waddr = count_r[IW-1:0];
    mem_wdata = '{beat: q_r, tempo: tempo_in_r, start: add_val};
    case (state_r)
      tmbtc_pkg::ST_IDLE: begin
        if (in_mode == tmbtc_pkg::MODE_APPEND) begin
          rd_addr = IW'(count_r - 1'b1);
        end
        if (in_acc && in_mode == tmbtc_pkg::MODE_APPEND && !full && count_r == '0) begin
          mem_we    = 1'b1;
          mem_wdata = '{beat: in_beat, tempo: in_tempo, start: 32'sd0};
        end
      end
      tmbtc_pkg::ST_SCAN: rd_addr = chk_idx_r + 1'b1;
      tmbtc_pkg::ST_ADD: begin
        mem_we = (mode_r == tmbtc_pkg::MODE_APPEND);
      end
      default: ;
    endcase
    cfg_pready = 1'b1;
    cfg_prdata = (cfg_paddr[2] == 1'b0) ? {13'd0, rate_r} : 32'd0;
  end

  // datapath
  always_comb begin
    mode_nxt       = mode_r;
    pt_nxt         = pt_r;
    count_nxt      = count_r;
    chk_idx_nxt    = chk_idx_r;
    q_nxt          = q_r;
    tempo_in_nxt   = tempo_in_r;
    phase2_nxt     = phase2_r;
    mul_a_nxt      = mul_a_r;
    mul_b_nxt      = mul_b_r;
    neg_nxt        = neg_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    iter_nxt       = iter_r;
    base_nxt       = base_r;
    res_sec_nxt    = res_sec_r;
    res_beat_nxt   = res_beat_r;
    res_tempo_nxt  = res_tempo_r;
    res_smp_nxt    = res_smp_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sec_nxt    = out_sec_r;
    out_beat_nxt   = out_beat_r;
    out_tempo_nxt  = out_tempo_r;
    out_smp_nxt    = out_smp_r;
    out_status_nxt = out_status_r;
    case (state_r)
      tmbtc_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_nxt       = in_mode;
          q_nxt          = (in_mode == tmbtc_pkg::MODE_S2B) ? in_secs : in_beat;
          tempo_in_nxt   = in_tempo;
          phase2_nxt     = 1'b0;
          chk_idx_nxt    = '0;
          pt_nxt         = DEFAULT_POINT;
          res_sec_nxt    = '0;
          res_beat_nxt   = '0;
          res_tempo_nxt  = '0;
          res_smp_nxt    = '0;
          res_status_nxt = tmbtc_pkg::STATUS_OK;
          case (in_mode)
            tmbtc_pkg::MODE_CLEAR: count_nxt = '0;
            tmbtc_pkg::MODE_APPEND: begin
              if (full) begin
                res_status_nxt = tmbtc_pkg::STATUS_FULL;
              end else if (count_r == '0) begin
                count_nxt = count_r + 1'b1;
              end
            end
            tmbtc_pkg::MODE_B2SMP: begin
              if (rate_zero) begin
                res_status_nxt = tmbtc_pkg::STATUS_ZERO_RATE;
              end
            end
            tmbtc_pkg::MODE_SMP2B: begin
              if (rate_zero) begin
                res_status_nxt = tmbtc_pkg::STATUS_ZERO_RATE;
              end
              dvd_nxt  = {smp_mag, 16'd0};
              neg_nxt  = in_smp[47];
              dvs_nxt  = rate_r;
              base_nxt = '0;
              rem_nxt  = '0;
              iter_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      tmbtc_pkg::ST_APP_RD: begin
        if (q_r < rd_data_r.beat) begin
          res_status_nxt = tmbtc_pkg::STATUS_ORDER;
        end else begin
          pt_nxt = rd_data_r;
        end
      end
      tmbtc_pkg::ST_SCAN: begin
        if (hit || chk_idx_r == '0) begin
          pt_nxt = rd_data_r;
        end
        if (hit && !last) begin
          chk_idx_nxt = chk_idx_r + 1'b1;
        end
      end
      tmbtc_pkg::ST_PICK: begin
        res_tempo_nxt = (mode_r == tmbtc_pkg::MODE_TEMPO) ? pt_r.tempo : '0;
        mul_a_nxt     = tmbtc_pkg::abs33(delta);
        neg_nxt       = delta[32];
        if (by_sec) begin
          mul_b_nxt = {2'b00, pt_tempo_c};
          dvs_nxt   = tmbtc_pkg::CENTI_SEC_PER_MIN;
          base_nxt  = pt_r.beat;
        end else begin
          mul_b_nxt = tmbtc_pkg::CENTI_SEC_PER_MIN;
          dvs_nxt   = {2'b00, pt_tempo_c};
          base_nxt  = pt_r.start;
        end
      end
      tmbtc_pkg::ST_MUL: begin
        dvd_nxt  = {12'd0, prod};
        rem_nxt  = '0;
        iter_nxt = '0;
      end
      tmbtc_pkg::ST_DIV: begin
        rem_nxt  = div_ge ? 19'(div_sh - {1'b0, dvs_r}) : div_sh[18:0];
        dvd_nxt  = {dvd_r[62:0], div_ge};
        iter_nxt = iter_r + 1'b1;
      end
      tmbtc_pkg::ST_ADD: begin
        case (mode_r)
          tmbtc_pkg::MODE_APPEND: count_nxt = count_r + 1'b1;
          tmbtc_pkg::MODE_B2S:    res_sec_nxt = add_val;
          tmbtc_pkg::MODE_S2B:    res_beat_nxt = add_val;
          tmbtc_pkg::MODE_B2SMP: begin
            res_sec_nxt = add_val;
            mul_a_nxt   = tmbtc_pkg::abs33({add_val[31], add_val});
            neg_nxt     = add_val[31];
            mul_b_nxt   = rate_r;
          end
          tmbtc_pkg::MODE_SMP2B: begin
            if (!phase2_r) begin
              res_sec_nxt = add_val;
              q_nxt       = add_val;
              phase2_nxt  = 1'b1;
              chk_idx_nxt = '0;
              pt_nxt      = DEFAULT_POINT;
            end else begin
              res_beat_nxt = add_val;
            end
          end
          default: ;
        endcase
      end
      tmbtc_pkg::ST_SMUL: begin
        res_smp_nxt = neg_r ? -$signed({12'd0, prod[51:16]}) : $signed({12'd0, prod[51:16]});
      end
      tmbtc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sec_nxt    = res_sec_r;
          out_beat_nxt   = res_beat_r;
          out_tempo_nxt  = res_tempo_r;
          out_smp_nxt    = res_smp_r;
          out_status_nxt = res_status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmbtc_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rate_r      <= tmbtc_pkg::RATE_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == 1'b0) begin
        rate_r <= cfg_pwdata[18:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    pt_r         <= pt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    q_r          <= q_nxt;
    tempo_in_r   <= tempo_in_nxt;
    phase2_r     <= phase2_nxt;
    mul_a_r      <= mul_a_nxt;
    mul_b_r      <= mul_b_nxt;
    neg_r        <= neg_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    dvs_r        <= dvs_nxt;
    iter_r       <= iter_nxt;
    base_r       <= base_nxt;
    res_sec_r    <= res_sec_nxt;
    res_beat_r   <= res_beat_nxt;
    res_tempo_r  <= res_tempo_nxt;
    res_smp_r    <= res_smp_nxt;
    res_status_r <= res_status_nxt;
    out_sec_r    <= out_sec_nxt;
    out_beat_r   <= out_beat_nxt;
    out_tempo_r  <= out_tempo_nxt;
    out_smp_r    <= out_smp_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_smp_r, out_tempo_r, out_beat_r, out_sec_r};
  assign out_tuser  = out_status_r;

  `TMBTC_ASSERT(a_count_bound, count_r <= CW'(MAX_POINTS), "point count past table size")
  `TMBTC_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `TMBTC_ASSERT_NXT(a_div_len, state_r == tmbtc_pkg::ST_DIV && (&iter_r), state_r == tmbtc_pkg::ST_ADD, "divide did not end")

endmodule

/* dv/testbench.sv */
// Testbench for tempo_map_beat_time_converter: random and directed tempo-map
// items checked against an in-bench predictor. Depends on tmbtc_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import tmbtc_pkg::*;

  localparam int              MAX_PTS         = MAX_POINTS_DEF;
  localparam logic [2:0]      MODE_UNUSED     = 3'd7;
  localparam logic [2:0]      REG_SAMPLE_RATE = 3'd0;
  localparam logic [16:0]     TEMPO_TOP       = 17'd99999;
  localparam logic [18:0]     RATE_TOP        = 19'd384000;
  localparam logic signed [31:0] Q_MAX32      = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN32      = 32'sh8000_0000;
  localparam logic signed [31:0] BEAT_4       = 32'sh0004_0000;
  localparam logic signed [47:0] SMP_MAX      = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SMP_MIN      = 48'sh8000_0000_0000;
  localparam longint          CENTI_SEC       = longint'(CENTI_SEC_PER_MIN);
  localparam longint          Q_ONE           = 65536;
  localparam int              ITEMS_PER_PHASE = 234;
  localparam int              N_PHASES        = 6;
  localparam int              HOLD_AT         = 300;
  localparam int              HOLD_CYCLES     = 2500;
  localparam int              DRAIN_CYCLES    = 400;
  localparam int              CYCLE_LIMIT     = 2_000_000;

  typedef struct packed {
    logic        [2:0]  mode;
    logic signed [31:0] beat;
    logic        [16:0] tempo;
    logic signed [31:0] secs;
    logic signed [47:0] smp;
  } conv_item_t;

  typedef struct packed {
    logic signed [31:0] sec;
    logic signed [31:0] beat;
    logic        [16:0] tempo;
    logic signed [47:0] smp;
    logic        [1:0]  status;
  } conv_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  tempo_map_beat_time_converter #(.MAX_POINTS(MAX_PTS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // predicted block state
  logic signed [31:0] pt_beat  [MAX_PTS];
  logic        [16:0] pt_tempo [MAX_PTS];
  logic signed [31:0] pt_start [MAX_PTS];
  int                 pt_count = 0;
  logic        [18:0] rate_hz = RATE_RESET;

  conv_item_t   pending_items[$];
  conv_result_t expected_results[$];
  longint       song_beats[$];
  int           items_made = 0;
  int           error_count = 0;
  int           results_seen = 0;
  int           cycle_count = 0;

  function automatic longint clip(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // last point whose beat (or start time) is at or below key
  function automatic int last_point_at(input longint key, input bit by_time);
    int idx;
    idx = 0;
    for (int i = 0; i < pt_count; i++) begin
      if ((by_time ? longint'(pt_start[i]) : longint'(pt_beat[i])) > key) break;
      idx = i;
    end
    return idx;
  endfunction

  // empty table reads as 120 BPM from beat 0 at 0 s
  function automatic void segment_of(input int idx, output longint b, output longint st,
                                     output logic [16:0] t, output longint tc);
    if (pt_count == 0) begin
      b = 0;
      st = 0;
      t = DEFAULT_TEMPO;
    end else begin
      b = pt_beat[idx];
      st = pt_start[idx];
      t = pt_tempo[idx];
    end
    tc = (t < MIN_TEMPO) ? MIN_TEMPO : t;
  endfunction

  function automatic longint time_in_segment(input int idx, input longint q);
    longint b, st, tc;
    logic [16:0] t;
    segment_of(idx, b, st, t, tc);
    return clip(st + (q - b) * CENTI_SEC / tc, 32);
  endfunction

  function automatic longint time_to_beats(input longint s);
    longint b, st, tc;
    logic [16:0] t;
    segment_of(last_point_at(s, 1'b1), b, st, t, tc);
    return clip(b + (s - st) * tc / CENTI_SEC, 32);
  endfunction

  function automatic conv_result_t tempo_map_convert(input conv_item_t it);
    conv_result_t r;
    longint q, sec, b, st, tc, rate, v;
    logic [16:0] t;
    r = '0;
    q = it.beat;
    rate = rate_hz;
    case (it.mode)
      MODE_CLEAR: pt_count = 0;
      MODE_APPEND: begin
        if (pt_count >= MAX_PTS) begin
          r.status = STATUS_FULL;
        end else if (pt_count > 0 && q < longint'(pt_beat[pt_count - 1])) begin
          r.status = STATUS_ORDER;
        end else begin
          sec = (pt_count > 0) ? time_in_segment(pt_count - 1, q) : 0;
          pt_beat[pt_count] = it.beat;
          pt_tempo[pt_count] = it.tempo;
          pt_start[pt_count] = 32'(sec);
          pt_count++;
        end
      end
      MODE_B2S: r.sec = 32'(time_in_segment(last_point_at(q, 1'b0), q));
      MODE_S2B: r.beat = 32'(time_to_beats(longint'(it.secs)));
      MODE_TEMPO: begin
        segment_of(last_point_at(q, 1'b0), b, st, t, tc);
        r.tempo = t;
      end
      MODE_B2SMP: begin
        if (rate == 0) begin
          r.status = STATUS_ZERO_RATE;
        end else begin
          sec = time_in_segment(last_point_at(q, 1'b0), q);
          r.sec = 32'(sec);
          r.smp = 48'(clip(sec * rate / Q_ONE, 48));
        end
      end
      MODE_SMP2B: begin
        if (rate == 0) begin
          r.status = STATUS_ZERO_RATE;
        end else begin
          sec = clip(longint'(it.smp) * Q_ONE / rate, 32);
          v = time_to_beats(sec);
          r.sec = 32'(sec);
          r.beat = 32'(v);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_results.push_back(tempo_map_convert(pending_items.pop_front()));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_items[0].mode;
        in_tdata <= {7'd0, pending_items[0].smp, pending_items[0].secs,
                     pending_items[0].tempo, pending_items[0].beat};
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int   stall_span = 0;
  int   stall_style = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_span <= $urandom_range(8, 150);
        stall_style <= $urandom_range(0, 3);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_style)
        2:       out_tready <= ($urandom_range(0, 3) != 0);
        3:       out_tready <= ($urandom_range(0, 4) == 0);
        default: out_tready <= 1'b1;
      endcase
    end
  end

  conv_result_t seen_result, due_result;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      seen_result.sec = out_tdata[31:0];
      seen_result.beat = out_tdata[63:32];
      seen_result.tempo = out_tdata[80:64];
      seen_result.smp = out_tdata[128:81];
      seen_result.status = out_tuser;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        due_result = expected_results.pop_front();
        if (seen_result.sec !== due_result.sec || seen_result.beat !== due_result.beat ||
            seen_result.tempo !== due_result.tempo || seen_result.smp !== due_result.smp ||
            seen_result.status !== due_result.status) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch at %0t: exp sec=%0d beat=%0d tempo=%0d smp=%0d status=%0d",
                     $realtime, due_result.sec, due_result.beat, due_result.tempo,
                     due_result.smp, due_result.status);
            $display("             got sec=%0d beat=%0d tempo=%0d smp=%0d status=%0d",
                     seen_result.sec, seen_result.beat, seen_result.tempo,
                     seen_result.smp, seen_result.status);
          end
        end
      end
    end
  end

  task automatic write_sample_rate(input logic [18:0] hz);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= REG_SAMPLE_RATE;
    cfg_pwdata <= 32'(hz);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rate_hz = hz;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (cfg_prdata !== 32'(hz)) begin
      error_count++;
      if (error_count <= 10) $display("sample rate readback: exp %0d got %0d", hz, cfg_prdata);
    end
  endtask

  function automatic logic [31:0] any32();
    return $urandom;
  endfunction

  function automatic logic [47:0] any48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic logic [16:0] rand_tempo();
    case ($urandom_range(0, 9))
      0:       return 17'($urandom_range(0, 9));
      1:       return 17'($urandom_range(99000, 99999));
      2:       return 17'($urandom_range(0, 99999));
      default: return 17'($urandom_range(3000, 30000));
    endcase
  endfunction

  function automatic logic signed [31:0] to_q32(input longint v);
    if (v > longint'(Q_MAX32)) return Q_MAX32;
    if (v < longint'(Q_MIN32)) return Q_MIN32;
    return 32'(v);
  endfunction

  task automatic queue_item(input logic [2:0] mode, input logic signed [31:0] beat,
                            input logic [16:0] tempo, input logic signed [31:0] secs,
                            input logic signed [47:0] smp);
    conv_item_t it;
    it.mode = mode;
    it.beat = beat;
    it.tempo = tempo;
    it.secs = secs;
    it.smp = smp;
    pending_items.push_back(it);
    items_made++;
  endtask

  // song_beats mirrors the beats the table should hold, to aim the queries
  task automatic queue_append(input longint nb);
    logic signed [31:0] qb;
    qb = to_q32(nb);
    queue_item(MODE_APPEND, qb, rand_tempo(), $signed(any32()), $signed(any48()));
    if (song_beats.size() == 0 ||
        (song_beats.size() < MAX_PTS && longint'(qb) >= song_beats[$]))
      song_beats.push_back(longint'(qb));
  endtask

  task automatic gen_query();
    logic [2:0]         m;
    longint             qb;
    logic signed [31:0] qs;
    logic signed [47:0] qn;
    int                 pick;
    case ($urandom_range(0, 19))
      0:       m = MODE_UNUSED;
      1:       m = MODE_APPEND;
      default: m = 3'($urandom_range(MODE_B2S, MODE_SMP2B));
    endcase
    pick = $urandom_range(0, 3);
    if (pick < 2 && song_beats.size() > 0)
      qb = song_beats[$urandom_range(0, song_beats.size() - 1)] +
           longint'($urandom_range(0, 1 << 18)) - (1 << 17);
    else if (pick < 3)
      qb = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
    else
      qb = longint'($signed(any32()));
    case ($urandom_range(0, 3))
      0, 1:    qs = 32'(longint'($urandom_range(0, 1 << 23)) - (1 << 22));
      2:       qs = 32'($urandom_range(0, 1 << 27));
      default: qs = $signed(any32());
    endcase
    case ($urandom_range(0, 3))
      0, 1:    qn = 48'(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
      2:       qn = $signed(any48()) >>> 12;
      default: qn = $signed(any48());
    endcase
    if (m == MODE_APPEND) begin
      if (song_beats.size() > 0 && $urandom_range(0, 1) == 0)
        queue_append(song_beats[$] + longint'($urandom_range(0, 1 << 20)));
      else
        queue_append(qb);
    end else begin
      queue_item(m, to_q32(qb), rand_tempo(), qs, qn);
    end
  endtask

  // clear, a run of appends in mostly ascending order, then queries
  task automatic gen_song(input int n_app);
    longint b;
    int     n_q;
    queue_item(MODE_CLEAR, $signed(any32()), rand_tempo(), $signed(any32()), $signed(any48()));
    song_beats.delete();
    b = ($urandom_range(0, 3) == 0) ? longint'($signed(any32()))
                                    : longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    for (int k = 0; k < n_app; k++) begin
      case ($urandom_range(0, 11))
        0:       queue_append(b);
        1:       queue_append(b + longint'($urandom_range(0, 1 << 28)));
        2:       queue_append(b - 1 - longint'($urandom_range(0, 1 << 18)));
        default: queue_append(b + longint'($urandom_range(1, 1 << 20)));
      endcase
      if (song_beats.size() > 0) b = song_beats[$];
    end
    n_q = $urandom_range(2, 24);
    for (int k = 0; k < n_q; k++) gen_query();
  endtask

  initial begin : stimulus
    int stop_at;
    logic [18:0] next_rate;
    while (!rst_n) @(posedge clk);
    @(negedge clk);
    // empty table: default tempo, saturation at both ends, odd mode
    queue_item(MODE_B2S, '0, '0, '0, '0);
    queue_item(MODE_B2S, Q_MAX32, '0, '0, '0);
    queue_item(MODE_B2S, Q_MIN32, '0, '0, '0);
    queue_item(MODE_S2B, '0, '0, Q_MAX32, '0);
    queue_item(MODE_S2B, '0, '0, Q_MIN32, '0);
    queue_item(MODE_TEMPO, 32'sh0003_0000, '0, '0, '0);
    queue_item(MODE_B2SMP, Q_MAX32, '0, '0, '0);
    queue_item(MODE_SMP2B, '0, '0, '0, SMP_MAX);
    queue_item(MODE_SMP2B, '0, '0, '0, SMP_MIN);
    queue_item(MODE_UNUSED, Q_MIN32, TEMPO_TOP, Q_MAX32, SMP_MIN);
    // first point off beat 0 with clamped tempo, equal beat, out of order
    queue_item(MODE_APPEND, BEAT_4, 17'd5, '0, '0);
    queue_item(MODE_APPEND, BEAT_4, TEMPO_TOP, '0, '0);
    queue_item(MODE_APPEND, 32'sh0001_0000, 17'd6000, '0, '0);
    queue_item(MODE_TEMPO, BEAT_4, '0, '0, '0);
    queue_item(MODE_B2S, Q_MIN32, '0, '0, '0);
    queue_item(MODE_S2B, '0, '0, Q_MIN32, '0);
    queue_item(MODE_APPEND, Q_MAX32, '0, '0, '0);
    queue_item(MODE_B2S, Q_MAX32, '0, '0, '0);
    queue_item(MODE_S2B, '0, '0, Q_MAX32, '0);
    queue_item(MODE_TEMPO, Q_MAX32, '0, '0, '0);
    queue_item(MODE_B2SMP, 32'sh0008_0000, '0, '0, '0);
    queue_item(MODE_SMP2B, '0, '0, '0, 48'sd96000);
    queue_item(MODE_CLEAR, '0, '0, '0, '0);
    queue_item(MODE_TEMPO, '0, '0, '0, '0);
    queue_item(MODE_APPEND, Q_MIN32, 17'd1, '0, '0);
    queue_item(MODE_B2S, Q_MAX32, '0, '0, '0);
    queue_item(MODE_B2SMP, Q_MAX32, '0, '0, '0);
    song_beats.delete();
    gen_song(MAX_PTS + 4);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        while (pending_items.size() != 0 || expected_results.size() != 0 || in_tvalid)
          @(posedge clk);
        repeat (4) @(posedge clk);
        case (ph)
          1:       next_rate = RATE_TOP;
          2:       next_rate = '0;
          3:       next_rate = 19'd1;
          4:       next_rate = 19'd44100;
          default: next_rate = 19'($urandom_range(1, RATE_TOP));
        endcase
        write_sample_rate(next_rate);
        @(negedge clk);
      end
      stop_at = items_made + ITEMS_PER_PHASE;
      while (items_made < stop_at)
        gen_song(($urandom_range(0, 9) == 0) ? $urandom_range(MAX_PTS - 4, MAX_PTS + 6)
                                             : $urandom_range(1, 8));
    end
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tmbtc_pkg.sv
rtl/core/tempo_map_beat_time_converter.sv
dv/testbench.sv
